[hdl/gcr_6and2_track_sector_decoder_defines.svh]
// Assertion macros shared by the sector decoder RTL.
// Relies on the including module having clk and rst in scope.
`ifndef GCR_6AND2_TRACK_SECTOR_DECODER_DEFINES_SVH
`define GCR_6AND2_TRACK_SECTOR_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define GCR62_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcr62 same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GCR62_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcr62 next-cycle check failed");

`else

`define GCR62_ASSERT_SAME(label, ante, cons)
`define GCR62_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/gcr62_pkg.sv]
// Shared types, constants and small decode functions for the 6-and-2 sector decoder.
// No dependencies.
package gcr62_pkg;

  localparam int SECTOR_COUNT           = 16;
  localparam int DATA_SEARCH_WINDOW_DEF = 117;
  localparam int AUX_COUNT              = 86;
  localparam int AUX_AW                 = $clog2(AUX_COUNT);
  localparam int DATA_NIBBLES           = 342;
  localparam int FC_W                   = 9;

  localparam logic [7:0] PRO_D5 = 8'hd5;
  localparam logic [7:0] PRO_AA = 8'haa;
  localparam logic [7:0] PRO_96 = 8'h96;
  localparam logic [7:0] PRO_AD = 8'had;
  localparam logic [7:0] MASK_EVEN = 8'h55;
  localparam logic [7:0] MASK_ODD  = 8'haa;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ADDR,
    PH_SEARCH,
    PH_DATA
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [3:0] sector_number;
    logic [1:0] status;
    logic       last;
    logic       track_complete;
  } gcr62_result_t;

  localparam logic [7:0] GCR62_TABLE [64] = '{
    8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
    8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
    8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
    8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
    8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
    8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
    8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
    8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
  };

  // Returns {valid, 6-bit value}; table entries are unique, so OR the hits.
  function automatic logic [6:0] gcr62_untranslate(input logic [7:0] nib);
    logic [6:0] r;
    r = '0;
    for (int k = 0; k < 64; k++) begin
      if (GCR62_TABLE[k] == nib) begin
        r = r | {1'b1, 6'(k)};
      end
    end
    return r;
  endfunction

  // 4-and-4: odd bits from the first nibble, even bits from the second.
  function automatic logic [7:0] gcr62_decode44(input logic [7:0] a, input logic [7:0] b);
    return ({a[6:0], 1'b0} & MASK_ODD) | (b & MASK_EVEN);
  endfunction

  // Aux bit pairs are stored swapped.
  function automatic logic [1:0] gcr62_swap2(input logic [1:0] b);
    return {b[0], b[1]};
  endfunction

endpackage

[hdl/gcr_6and2_track_sector_decoder.sv]
// 6-and-2 GCR track sector decoder, top level. Depends on gcr62_pkg, gcr62_aux_ram,
// gcr62_out_skid and the defines header.
// Throughput: one nibble per cycle while s_axis_tready is high; each word is decoded
// in full in the cycle it is accepted, and its result word is registered before m_axis.
// s_axis_tready drops only while the skid word is occupied (output stalled two words deep).
// Reset (rst, synchronous): parser back to address hunt, sector map cleared, expected
// track 0. The aux memory is not cleared; every sector fills it before reading it.
`include "gcr_6and2_track_sector_decoder_defines.svh"

module gcr_6and2_track_sector_decoder
  import gcr62_pkg::*;
#(
  parameter int DATA_SEARCH_WINDOW = DATA_SEARCH_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write: expected_track
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // nibble stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] nibble
  input  logic        s_axis_tuser,   // [0] track_start
  // decoded word stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index,
                                      // [19:16] sector_number, [20] track_complete, rest 0
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);

  // Search window counter saturates at the window size; only < / >= window matters.
  localparam int WIN_W = $clog2(DATA_SEARCH_WINDOW + 1);
  localparam logic [WIN_W-1:0] WIN_LIMIT = WIN_W'(DATA_SEARCH_WINDOW);
  localparam logic [FC_W-1:0]  FC_AUX    = FC_W'(AUX_COUNT);
  localparam logic [FC_W-1:0]  FC_LANE1  = FC_W'(2 * AUX_COUNT);
  localparam logic [FC_W-1:0]  FC_LANE2  = FC_W'(3 * AUX_COUNT);
  localparam logic [FC_W-1:0]  FC_END    = FC_W'(DATA_NIBBLES);
  localparam logic [FC_W-1:0]  FC_ADDR_LAST = FC_W'(7);

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic [1:0]        pm, pm_next;             // prologue match progress
  logic [FC_W-1:0]   fc, fc_next;             // field / data nibble counter
  logic [7:0]        held, held_next;         // first half of a 4-and-4 pair
  logic [7:0]        addr_vol, addr_vol_next;
  logic [7:0]        addr_trk, addr_trk_next;
  logic [7:0]        addr_sec, addr_sec_next;
  logic [WIN_W-1:0]  win, win_next;
  logic [5:0]        xc, xc_next;             // running XOR chain
  logic [SECTOR_COUNT-1:0] seen, seen_next;
  logic [7:0]        expected_track;

  // Effective state after an optional track start on this word.
  phase_t            ph_e;
  logic [1:0]        pm_e;
  logic [FC_W-1:0]   fc_e;
  logic [7:0]        held_e;
  logic [WIN_W-1:0]  win_e;
  logic [5:0]        xc_e;
  logic [SECTOR_COUNT-1:0] seen_e;

  logic        accept;
  logic        room;
  logic [7:0]  nib;
  logic [6:0]  untr;
  logic        t_ok;
  logic [5:0]  t_val;
  logic [5:0]  chain_v;
  logic [7:0]  pair_v;
  logic        addr_ok;

  // Aux memory ports
  logic              aux_we;
  logic [AUX_AW-1:0] aux_waddr;
  logic [5:0]        aux_rdata;
  logic [AUX_AW-1:0] aux_raddr;
  logic [FC_W-1:0]   fc_adv;

  // Result
  logic          push;
  gcr62_result_t res;
  gcr62_result_t out_word;
  logic [1:0]    lane;
  logic [FC_W-1:0] byte_i;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign nib           = s_axis_tdata;

  assign untr  = gcr62_untranslate(nib);
  assign t_ok  = untr[6];
  assign t_val = untr[5:0];

  always_comb begin
    if (s_axis_tuser) begin
      ph_e   = PH_HUNT;
      pm_e   = 2'd0;
      fc_e   = '0;
      held_e = '0;
      win_e  = '0;
      xc_e   = '0;
      seen_e = '0;
    end else begin
      ph_e   = phase;
      pm_e   = pm;
      fc_e   = fc;
      held_e = held;
      win_e  = win;
      xc_e   = xc;
      seen_e = seen;
    end
  end

  assign chain_v = t_val ^ xc_e;
  assign pair_v  = gcr62_decode44(held_e, nib);
  assign addr_ok = (addr_sec < 8'(SECTOR_COUNT)) && (addr_trk == expected_track) &&
                   ((addr_vol ^ addr_trk ^ addr_sec) == pair_v);

  // Lane of the aux value used by the current data byte.
  always_comb begin
    if (fc_e >= FC_LANE2) begin
      lane = 2'd2;
    end else if (fc_e >= FC_LANE1) begin
      lane = 2'd1;
    end else begin
      lane = 2'd0;
    end
  end
  assign byte_i = fc_e - FC_AUX;

  // ---------------------------------------------------------------------------
  // Next phase
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_next = ph_e;
    case (ph_e)
      PH_ADDR: begin
        if (fc_e == FC_ADDR_LAST) begin
          phase_next = addr_ok ? PH_SEARCH : PH_HUNT;
        end
      end
      PH_SEARCH: begin
        if (pm_e == 2'd2 && nib == PRO_AD) begin
          phase_next = PH_DATA;
        end else if (!(pm_e == 2'd1 && nib == PRO_AA) &&
                     !(nib == PRO_D5 && win_e < WIN_LIMIT) &&
                     win_e >= WIN_LIMIT) begin
          phase_next = PH_HUNT;
        end
      end
      PH_DATA: begin
        if (fc_e >= FC_END || !t_ok) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        phase_next = (pm_e == 2'd2 && nib == PRO_96) ? PH_ADDR : PH_HUNT;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath: field capture, chain, aux write, result word
  // ---------------------------------------------------------------------------
  always_comb begin
    pm_next       = pm_e;
    fc_next       = fc_e;
    held_next     = held_e;
    win_next      = win_e;
    xc_next       = xc_e;
    seen_next     = seen_e;
    addr_vol_next = addr_vol;
    addr_trk_next = addr_trk;
    addr_sec_next = addr_sec;
    aux_we        = 1'b0;
    push          = 1'b0;
    res.data_byte     = '0;
    res.byte_index    = '0;
    res.sector_number = addr_sec[3:0];
    res.status        = ST_DATA;
    res.last          = 1'b0;
    res.track_complete = 1'b0;

    case (ph_e)
      PH_ADDR: begin
        fc_next = fc_e + FC_W'(1);
        if (!fc_e[0]) begin
          held_next = nib;
        end else begin
          case (fc_e[2:1])
            2'd0: addr_vol_next = pair_v;
            2'd1: addr_trk_next = pair_v;
            2'd2: addr_sec_next = pair_v;
            default: begin
              // checksum pair closes the field
              fc_next  = '0;
              pm_next  = 2'd0;
              win_next = '0;
            end
          endcase
        end
      end
      PH_SEARCH: begin
        if (win_e < WIN_LIMIT) begin
          win_next = win_e + WIN_W'(1);
        end
        if (pm_e == 2'd1 && nib == PRO_AA) begin
          pm_next = 2'd2;
        end else if (pm_e == 2'd2 && nib == PRO_AD) begin
          pm_next = 2'd0;
          fc_next = '0;
          xc_next = '0;
        end else if (nib == PRO_D5 && win_e < WIN_LIMIT) begin
          pm_next = 2'd1;
        end else if (win_e >= WIN_LIMIT) begin
          // window gone: this nibble may start an address prologue
          pm_next = (nib == PRO_D5) ? 2'd1 : 2'd0;
        end else begin
          pm_next = 2'd0;
        end
      end
      PH_DATA: begin
        if (fc_e >= FC_END || !t_ok) begin
          pm_next   = 2'd0;
          fc_next   = '0;
          held_next = '0;
          win_next  = '0;
          xc_next   = '0;
          push      = 1'b1;
          res.last  = 1'b1;
          if (fc_e >= FC_END && t_ok && t_val == xc_e) begin
            seen_next  = seen_e | (SECTOR_COUNT'(1) << addr_sec[3:0]);
            res.status = ST_GOOD;
          end else begin
            res.status = ST_BAD;
          end
        end else begin
          xc_next = chain_v;
          fc_next = fc_e + FC_W'(1);
          if (fc_e < FC_AUX) begin
            aux_we = 1'b1;
          end else begin
            push           = 1'b1;
            res.byte_index = byte_i[7:0];
            res.data_byte  = {chain_v,
                              gcr62_swap2(aux_rdata[{lane, 1'b0} +: 2])};
          end
        end
      end
      default: begin
        if (pm_e == 2'd1 && nib == PRO_AA) begin
          pm_next = 2'd2;
        end else if (pm_e == 2'd2 && nib == PRO_96) begin
          pm_next   = 2'd0;
          fc_next   = '0;
          held_next = '0;
        end else begin
          pm_next = (nib == PRO_D5) ? 2'd1 : 2'd0;
        end
      end
    endcase

    res.track_complete = &seen_next;
  end

  // ---------------------------------------------------------------------------
  // Aux memory. Address the read from the counter value that the next word will
  // see, so the registered data lines up with it. Writes (aux run) always finish
  // before any read of the same sector, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  assign aux_waddr = fc_e[AUX_AW-1:0];
  assign fc_adv    = accept ? fc_next : fc;

  always_comb begin
    if (fc_adv >= FC_LANE2) begin
      aux_raddr = AUX_AW'(fc_adv - FC_LANE2);
    end else if (fc_adv >= FC_LANE1) begin
      aux_raddr = AUX_AW'(fc_adv - FC_LANE1);
    end else if (fc_adv >= FC_AUX) begin
      aux_raddr = AUX_AW'(fc_adv - FC_AUX);
    end else begin
      aux_raddr = fc_adv[AUX_AW-1:0];
    end
  end

  gcr62_aux_ram u_aux_ram (
    .clk   (clk),
    .we    (aux_we && accept),
    .waddr (aux_waddr),
    .wdata (chain_v),
    .raddr (aux_raddr),
    .rdata (aux_rdata)
  );

  // ---------------------------------------------------------------------------
  // State registers: advance only on an accepted word.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      pm       <= 2'd0;
      fc       <= '0;
      held     <= '0;
      addr_vol <= '0;
      addr_trk <= '0;
      addr_sec <= '0;
      win      <= '0;
      xc       <= '0;
      seen     <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      pm       <= pm_next;
      fc       <= fc_next;
      held     <= held_next;
      addr_vol <= addr_vol_next;
      addr_trk <= addr_trk_next;
      addr_sec <= addr_sec_next;
      win      <= win_next;
      xc       <= xc_next;
      seen     <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_track <= '0;
    end else if (cfg_valid && cfg_ready) begin
      expected_track <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and skid word
  // ---------------------------------------------------------------------------
  gcr62_out_skid u_out_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push && accept),
    .push_word (res),
    .has_room  (room),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {3'b000, out_word.track_complete, out_word.sector_number,
                         out_word.byte_index, out_word.data_byte};
  assign m_axis_tuser = out_word.status;
  assign m_axis_tlast = out_word.last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `GCR62_ASSERT_SAME(a_skid_behind_out, !room, m_axis_tvalid)
  `GCR62_ASSERT_SAME(a_aux_write_in_aux_run, aux_we, (phase == PH_DATA) && (fc < FC_AUX))
  `GCR62_ASSERT_SAME(a_data_word_after_aux, push && accept && res.status == ST_DATA,
                     (phase == PH_DATA) && (fc >= FC_AUX) && (fc < FC_END))
  `GCR62_ASSERT_NEXT(a_track_start_clears_map, accept && s_axis_tuser, seen == '0)

endmodule

[hdl/gcr62_aux_ram.sv]
// Auxiliary-value store: 86 x 6 bit, one write port, one read port, registered read.
// Depends on gcr62_pkg.
module gcr62_aux_ram
  import gcr62_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [AUX_AW-1:0] waddr,
  input  logic [5:0]        wdata,
  input  logic [AUX_AW-1:0] raddr,
  output logic [5:0]        rdata
);

  logic [5:0] mem [AUX_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/gcr62_out_skid.sv]
// Output register plus one skid word for decoded results.
// Depends on gcr62_pkg.
module gcr62_out_skid
  import gcr62_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gcr62_result_t push_word,
  output logic          has_room,
  output logic          out_valid,
  input  logic          out_ready,
  output gcr62_result_t out_word
);

  logic          skid_valid;
  gcr62_result_t skid_word;
  logic          pop;

  assign pop      = out_valid && out_ready;
  assign has_room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_word <= push_word;
      end else begin
        out_word <= push_word;
      end
    end
  end

endmodule
